// ===== hw/rtl/vds_pkg.sv =====
// vds_pkg: shared types and constants of the vector direction sector block
// used by every module under hw/rtl; depends on nothing else

package vds_pkg;

  typedef enum logic {
    SECT_8  = 1'b0,
    SECT_16 = 1'b1
  } sector_mode_e;

  // ratio scale and tangent thresholds, eight-sector pair first
  localparam int unsigned RatioScale = 1000;
  localparam int unsigned NumThr     = 6;
  localparam int unsigned ThrBits    = 13;
  localparam logic [ThrBits-1:0] Thr [NumThr] = '{
    13'd414, 13'd2414, 13'd199, 13'd668, 13'd1496, 13'd5027
  };

  localparam int unsigned SectorBits = 4;

  typedef struct packed {
    sector_mode_e mode;
    logic         x_zero;
    logic         x_pos;
    logic         y_zero;
    logic         y_pos;
  } dir_flags_t;

endpackage

// ===== hw/rtl/vds_front.sv =====
// vds_front: difference stage and magnitude stage of the sector pipeline
// depends on vds_pkg for the mode type and the direction flags struct

module vds_front #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  vds_pkg::sector_mode_e       mode_i,
  input  logic signed [COORD_BITS-1:0] target_x_i,
  input  logic signed [COORD_BITS-1:0] target_y_i,
  input  logic signed [COORD_BITS-1:0] origin_x_i,
  input  logic signed [COORD_BITS-1:0] origin_y_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic [COORD_BITS:0]         abs_x_o,
  output logic [COORD_BITS:0]         abs_y_o,
  output vds_pkg::dir_flags_t         flags_o
);

  localparam int unsigned DW = COORD_BITS + 1;

  logic                  s1_valid_q, s2_valid_q;
  logic                  s1_stall, s2_stall;
  logic signed [DW-1:0]  dx_d, dx_q, dy_d, dy_q;
  vds_pkg::sector_mode_e mode_q;
  logic [DW-1:0]         ax_d, ax_q, ay_d, ay_q;
  vds_pkg::dir_flags_t   flags_d, flags_q;

  assign s2_stall = s2_valid_q & stall_i;
  assign s1_stall = s1_valid_q & s2_stall;
  assign stall_o  = s1_stall;

  // north is positive dy, so origin minus target
  assign dx_d = DW'(target_x_i) - DW'(origin_x_i);
  assign dy_d = DW'(origin_y_i) - DW'(target_y_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (!s1_stall) s1_valid_q <= valid_i;
      if (!s2_stall) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!s1_stall && valid_i) begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      mode_q <= mode_i;
    end
  end

  always_comb begin
    ax_d           = dx_q[DW-1] ? DW'(-dx_q) : DW'(dx_q);
    ay_d           = dy_q[DW-1] ? DW'(-dy_q) : DW'(dy_q);
    flags_d.mode   = mode_q;
    flags_d.x_zero = (dx_q == '0);
    flags_d.x_pos  = !dx_q[DW-1] && (dx_q != '0);
    flags_d.y_zero = (dy_q == '0);
    flags_d.y_pos  = !dy_q[DW-1] && (dy_q != '0);
  end

  always_ff @(posedge clk_i) begin
    if (!s2_stall && s1_valid_q) begin
      ax_q    <= ax_d;
      ay_q    <= ay_d;
      flags_q <= flags_d;
    end
  end

  assign valid_o = s2_valid_q;
  assign abs_x_o = ax_q;
  assign abs_y_o = ay_q;
  assign flags_o = flags_q;

endmodule

// ===== hw/rtl/vds_scale.sv =====
// vds_scale: constant multiply stage, scaled |dy| and |dx| times each threshold
// depends on vds_pkg for the threshold table and the direction flags struct

module vds_scale #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       stall_o,
  input  logic [COORD_BITS:0]        abs_x_i,
  input  logic [COORD_BITS:0]        abs_y_i,
  input  vds_pkg::dir_flags_t        flags_i,
  output logic                       valid_o,
  input  logic                       stall_i,
  output logic [COORD_BITS+12:0]     lhs_o,
  output logic [COORD_BITS+12:0]     prod_o [vds_pkg::NumThr],
  output vds_pkg::dir_flags_t        flags_o
);

  localparam int unsigned PW = COORD_BITS + 1 + vds_pkg::ThrBits - 1;

  logic                valid_q;
  logic [PW-1:0]       lhs_d, lhs_q;
  logic [PW-1:0]       prod_d [vds_pkg::NumThr];
  logic [PW-1:0]       prod_q [vds_pkg::NumThr];
  vds_pkg::dir_flags_t flags_q;

  assign stall_o = valid_q & stall_i;

  always_comb begin
    lhs_d = PW'(abs_y_i) * PW'(vds_pkg::RatioScale);
    for (int i = 0; i < vds_pkg::NumThr; i++) begin
      prod_d[i] = PW'(abs_x_i) * PW'(vds_pkg::Thr[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      lhs_q   <= lhs_d;
      prod_q  <= prod_d;
      flags_q <= flags_i;
    end
  end

  assign valid_o = valid_q;
  assign lhs_o   = lhs_q;
  assign prod_o  = prod_q;
  assign flags_o = flags_q;

endmodule

// ===== hw/rtl/vds_sector.sv =====
// vds_sector: threshold compare, sector count and the output register
// depends on vds_pkg for the mode type, the table size and the flags struct

module vds_sector #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              stall_o,
  input  logic [COORD_BITS+12:0]            lhs_i,
  input  logic [COORD_BITS+12:0]            prod_i [vds_pkg::NumThr],
  input  vds_pkg::dir_flags_t               flags_i,
  output logic                              valid_o,
  input  logic                              stall_i,
  output logic [vds_pkg::SectorBits-1:0]    sector_o
);

  logic                            valid_q;
  logic [vds_pkg::NumThr-1:0]      ge;
  logic [2:0]                      k;
  logic [4:0]                      q, q3, sec, mask;
  logic [vds_pkg::SectorBits-1:0]  sector_d, sector_q;

  assign stall_o = valid_q & stall_i;

  always_comb begin
    for (int i = 0; i < vds_pkg::NumThr; i++) begin
      ge[i] = (lhs_i >= prod_i[i]);
    end
    unique case (flags_i.mode)
      vds_pkg::SECT_16: begin
        k    = 3'(ge[2]) + 3'(ge[3]) + 3'(ge[4]) + 3'(ge[5]);
        q    = 5'd4;
        mask = 5'd15;
      end
      default: begin
        k    = 3'(ge[0]) + 3'(ge[1]);
        q    = 5'd2;
        mask = 5'd7;
      end
    endcase
    q3 = 5'(q * 5'd3);
    priority if (flags_i.x_zero) begin
      sec = flags_i.y_pos ? 5'd0 : 5'(q << 1);
    end else if (flags_i.y_zero) begin
      sec = flags_i.x_pos ? q : q3;
    end else if (flags_i.x_pos) begin
      sec = flags_i.y_pos ? (q - 5'(k)) : (q + 5'(k));
    end else begin
      sec = flags_i.y_pos ? (q3 + 5'(k)) : (q3 - 5'(k));
    end
    sector_d = vds_pkg::SectorBits'(sec & mask);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      sector_q <= sector_d;
    end
  end

  assign valid_o  = valid_q;
  assign sector_o = sector_q;

endmodule

// ===== hw/rtl/vector_direction_sector.sv =====
// vector_direction_sector: top level, mode register and the four stage pipeline
// depends on vds_pkg, vds_front, vds_scale and vds_sector
// throughput: one beat per cycle through the difference, magnitude, multiply
// and compare stages; a stall holds a stage only while it and each later stage are full
// reset clears the stage valid bits and sets the mode register to eight sectors

module vector_direction_sector #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic                                 cfg_sector_mode_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [COORD_BITS-1:0]         target_x_i,
  input  logic signed [COORD_BITS-1:0]         target_y_i,
  input  logic signed [COORD_BITS-1:0]         origin_x_i,
  input  logic signed [COORD_BITS-1:0]         origin_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [vds_pkg::SectorBits-1:0]       sector_o
);

  vds_pkg::sector_mode_e mode_q;

  logic                  fr_valid, fr_stall;
  logic [COORD_BITS:0]   abs_x, abs_y;
  vds_pkg::dir_flags_t   fr_flags;

  logic                  sc_valid, sc_stall;
  logic [COORD_BITS+12:0] lhs;
  logic [COORD_BITS+12:0] prod [vds_pkg::NumThr];
  vds_pkg::dir_flags_t   sc_flags;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= vds_pkg::SECT_8;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= vds_pkg::sector_mode_e'(cfg_sector_mode_i);
    end
  end

  vds_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid_i),
    .stall_o    (in_stall_o),
    .mode_i     (mode_q),
    .target_x_i (target_x_i),
    .target_y_i (target_y_i),
    .origin_x_i (origin_x_i),
    .origin_y_i (origin_y_i),
    .valid_o    (fr_valid),
    .stall_i    (fr_stall),
    .abs_x_o    (abs_x),
    .abs_y_o    (abs_y),
    .flags_o    (fr_flags)
  );

  vds_scale #(.COORD_BITS(COORD_BITS)) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .stall_o (fr_stall),
    .abs_x_i (abs_x),
    .abs_y_i (abs_y),
    .flags_i (fr_flags),
    .valid_o (sc_valid),
    .stall_i (sc_stall),
    .lhs_o   (lhs),
    .prod_o  (prod),
    .flags_o (sc_flags)
  );

  vds_sector #(.COORD_BITS(COORD_BITS)) u_sector (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sc_valid),
    .stall_o  (sc_stall),
    .lhs_i    (lhs),
    .prod_i   (prod),
    .flags_i  (sc_flags),
    .valid_o  (out_valid_o),
    .stall_i  (out_stall_i),
    .sector_o (sector_o)
  );

  // eight-sector mode never yields a code above seven
  a_mode8_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_q == vds_pkg::SECT_8) |-> !sector_o[3])
    else $error("sector out of range in eight-sector mode");

  // back pressure only starts at the output side
  a_stall_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i)
    else $error("input stalled without output stall");

  // an accepted beat reaches the output when the output does not stall meanwhile
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
    |=> out_valid_o)
    else $error("accepted beat did not reach the output");

endmodule

// ===== bench/testbench.sv =====
// testbench for vector_direction_sector: random and directed point pairs, both sector modes
// depends on vds_pkg and the vector_direction_sector rtl; predicts each sector in place
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CoordBits = 16;
  localparam int unsigned WatchLimit = 1000;
  localparam int unsigned DrainCycles = 12;

  typedef struct {
    logic signed [CoordBits-1:0] target_x;
    logic signed [CoordBits-1:0] target_y;
    logic signed [CoordBits-1:0] origin_x;
    logic signed [CoordBits-1:0] origin_y;
  } point_pair_t;

  localparam int ThrEight[2]   = '{414, 2414};
  localparam int ThrSixteen[4] = '{199, 668, 1496, 5027};
  localparam int ThrAll[6]     = '{414, 2414, 199, 668, 1496, 5027};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_sector_mode_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [CoordBits-1:0] target_x_i = '0;
  logic signed [CoordBits-1:0] target_y_i = '0;
  logic signed [CoordBits-1:0] origin_x_i = '0;
  logic signed [CoordBits-1:0] origin_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [vds_pkg::SectorBits-1:0] sector_o;

  point_pair_t pending_pairs[$];
  logic [vds_pkg::SectorBits-1:0] expected_sectors[$];
  vds_pkg::sector_mode_e mode_q = vds_pkg::SECT_8;
  bit calm = 1'b0;
  int mismatch_count = 0;
  int idle_cycles = 0;

  vector_direction_sector #(
    .COORD_BITS(CoordBits)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_sector_mode_i(cfg_sector_mode_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .target_x_i       (target_x_i),
    .target_y_i       (target_y_i),
    .origin_x_i       (origin_x_i),
    .origin_y_i       (origin_y_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .sector_o         (sector_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [vds_pkg::SectorBits-1:0] compass_sector(
      vds_pkg::sector_mode_e mode, point_pair_t p);
    longint dx, dy, ax, ay;
    int n, q, k, sec;
    dx = longint'(p.target_x) - longint'(p.origin_x);
    dy = longint'(p.origin_y) - longint'(p.target_y);
    n = (mode == vds_pkg::SECT_16) ? 16 : 8;
    q = n / 4;
    k = 0;
    if (dx == 0) begin
      sec = (dy > 0) ? 0 : 2 * q;
    end else if (dy == 0) begin
      sec = (dx > 0) ? q : 3 * q;
    end else begin
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      if (mode == vds_pkg::SECT_16) begin
        foreach (ThrSixteen[i]) if (ay * 1000 >= longint'(ThrSixteen[i]) * ax) k++;
      end else begin
        foreach (ThrEight[i]) if (ay * 1000 >= longint'(ThrEight[i]) * ax) k++;
      end
      if (dx > 0) sec = (dy > 0) ? q - k : q + k;
      else sec = (dy > 0) ? 3 * q + k : 3 * q - k;
      sec = sec & (n - 1);
    end
    return sec[vds_pkg::SectorBits-1:0];
  endfunction

  function automatic point_pair_t make_pair(int tx, int ty, int ox, int oy);
    point_pair_t p;
    p.target_x = CoordBits'(tx);
    p.target_y = CoordBits'(ty);
    p.origin_x = CoordBits'(ox);
    p.origin_y = CoordBits'(oy);
    return p;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(0, 3))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return $urandom_range(0, 65535) - 32768;
    endcase
  endfunction

  function automatic point_pair_t random_pair();
    int pick, ox, oy, m, ax, ay, sx, sy;
    point_pair_t p;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      p = make_pair($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                    $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768);
    end else if (pick < 60) begin
      ox = $urandom_range(0, 60000) - 30000;
      oy = $urandom_range(0, 60000) - 30000;
      p = make_pair(ox + $urandom_range(0, 8) - 4, oy + $urandom_range(0, 8) - 4, ox, oy);
    end else if (pick < 90) begin
      // ratio on or next to a tangent threshold
      ox = $urandom_range(0, 2000) - 1000;
      oy = $urandom_range(0, 2000) - 1000;
      m = $urandom_range(1, 6);
      ax = 1000 * m;
      ay = ThrAll[$urandom_range(0, 5)] * m + $urandom_range(0, 2) - 1;
      sx = $urandom_range(0, 1) ? 1 : -1;
      sy = $urandom_range(0, 1) ? 1 : -1;
      p = make_pair(ox + sx * ax, oy + sy * ay, ox, oy);
    end else begin
      p = make_pair(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
    end
    return p;
  endfunction

  task automatic add_pair(point_pair_t p);
    pending_pairs.insert(pending_pairs.size(), p);
  endtask

  task automatic queue_directed();
    add_pair(make_pair(0, 0, 0, 0));
    add_pair(make_pair(-32768, 32767, -32768, 32767));
    add_pair(make_pair(5, -100, 5, 100));
    add_pair(make_pair(5, 100, 5, -100));
    add_pair(make_pair(100, 3, -100, 3));
    add_pair(make_pair(-100, 3, 100, 3));
    add_pair(make_pair(32767, -32768, -32768, 32767));
    add_pair(make_pair(-32768, 32767, 32767, -32768));
    add_pair(make_pair(32767, 0, -32768, 0));
    add_pair(make_pair(0, 32767, 0, -32768));
    add_pair(make_pair(500, -207, 0, 0));
    add_pair(make_pair(-500, 207, 0, 0));
    add_pair(make_pair(500, -206, 0, 0));
    add_pair(make_pair(500, -1207, 0, 0));
    add_pair(make_pair(-500, -1207, 0, 0));
    add_pair(make_pair(1000, -199, 0, 0));
    add_pair(make_pair(-250, 167, 0, 0));
    add_pair(make_pair(125, -187, 0, 0));
    add_pair(make_pair(-125, -187, 0, 0));
    add_pair(make_pair(1000, 5027, 0, 0));
    add_pair(make_pair(-1000, -5026, 0, 0));
    add_pair(make_pair(1000, -5028, 0, 0));
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (!(pending_pairs.size() == 0 && !in_valid_i && expected_sectors.size() == 0));
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(vds_pkg::sector_mode_e m);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_sector_mode_i <= m;
    do @(posedge clk_i);
    while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    mode_q = m;
  endtask

  task automatic queue_random(int count);
    repeat (count) add_pair(random_pair());
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : coord_driver
    point_pair_t p;
    if (in_valid_i && in_stall_o === 1'b0) begin
      p.target_x = target_x_i;
      p.target_y = target_y_i;
      p.origin_x = origin_x_i;
      p.origin_y = origin_y_i;
      expected_sectors.insert(expected_sectors.size(), compass_sector(mode_q, p));
    end
    if (in_valid_i && in_stall_o !== 1'b0) begin
      // stalled beat holds
    end else if (rst_ni && pending_pairs.size() > 0 &&
                 (calm || $urandom_range(0, 99) >= 18)) begin
      p = pending_pairs.pop_front();
      in_valid_i <= 1'b1;
      target_x_i <= p.target_x;
      target_y_i <= p.target_y;
      origin_x_i <= p.origin_x;
      origin_y_i <= p.origin_y;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : sector_monitor
    logic [vds_pkg::SectorBits-1:0] want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (expected_sectors.size() == 0) begin
        report_mismatch($sformatf("unexpected beat, sector %0d", sector_o));
      end else begin
        want = expected_sectors.pop_front();
        if (sector_o !== want)
          report_mismatch($sformatf("sector %0d, expected %0d", sector_o, want));
      end
    end
    out_stall_i <= rst_ni && !calm && ($urandom_range(0, 99) < 18);
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("timeout after %0d cycles without a beat", idle_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    #1 rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_directed();
    write_mode(vds_pkg::SECT_16);
    queue_directed();
    write_mode(vds_pkg::SECT_8);
    queue_random(330);
    write_mode(vds_pkg::SECT_16);
    calm = 1'b1;
    queue_random(330);
    wait_drained();
    calm = 1'b0;
    write_mode(vds_pkg::SECT_8);
    queue_random(330);
    write_mode(vds_pkg::SECT_16);
    queue_random(330);
    wait_drained();

    if (expected_sectors.size() != 0)
      report_mismatch($sformatf("%0d beats never arrived", expected_sectors.size()));
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
